// File: hw/rtl/bfse_pkg.sv
package bfse_pkg;

  localparam int unsigned MAP_BITS_DEF      = 65536;
  localparam int unsigned MAX_KEY_BYTES_DEF = 64;
  localparam int unsigned MAX_HASHES_DEF    = 32;

  localparam int unsigned HDR_BYTES   = 36;
  localparam int unsigned SEED_BITS   = 256;
  localparam int unsigned BLOCK_BITS  = 512;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned SHA_ROUNDS  = 64;
  localparam int unsigned LEN_BYTES   = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic FUNC_ADD        = 1'b0;
  localparam logic FUNC_TEST       = 1'b1;
  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED0      = 3'd0,
    REG_SEED1      = 3'd1,
    REG_SEED2      = 3'd2,
    REG_SEED3      = 3'd3,
    REG_MAP_LOG2   = 3'd4,
    REG_HASH_COUNT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic clearing;
    logic pop;
    logic job_done;
  } bk_stat_t;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: hw/rtl/bfse_front.sv
module bfse_front #(
  parameter int unsigned MAX_KEY_BYTES = bfse_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_func,
  input  logic [7:0]                            in_key_byte,
  input  logic                                  in_byte_valid,
  input  logic                                  in_last,
  input  bfse_pkg::bk_stat_t                    stat,
  output logic                                  q_valid,
  output logic                                  q_func,
  output logic [$clog2(MAX_KEY_BYTES+1)-1:0]    q_len,
  output logic                                  q_ovf,
  output logic                                  q_slot,
  output logic                                  kwr_en,
  output logic [$clog2(2*MAX_KEY_BYTES)-1:0]    kwr_addr,
  output logic [7:0]                            kwr_data
);

  localparam int unsigned LENW = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned KAW  = $clog2(2 * MAX_KEY_BYTES);
  localparam logic [1:0] SLOTS = 2'd2;

  logic [LENW-1:0] len_r, len_nxt;
  logic            ovf_r, ovf_nxt;
  logic            slot_r;
  logic [1:0]      cnt_r;
  logic            q_valid_r, q_func_r, q_ovf_r, q_slot_r;
  logic [LENW-1:0] q_len_r;
  logic            acc, push, room;

  assign in_stall = stat.clearing | (cnt_r == SLOTS) | q_valid_r;
  assign acc      = in_valid & ~in_stall;
  assign push     = acc & in_last;
  assign room     = len_r < LENW'(MAX_KEY_BYTES);

  assign kwr_en   = acc & in_byte_valid & room;
  assign kwr_addr = slot_r ? KAW'(MAX_KEY_BYTES) + KAW'(len_r) : KAW'(len_r);
  assign kwr_data = in_key_byte;

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (acc && in_byte_valid) begin
      if (room) begin
        len_nxt = len_r + LENW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      ovf_r     <= 1'b0;
      slot_r    <= 1'b0;
      cnt_r     <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (push) begin
        len_r     <= '0;
        ovf_r     <= 1'b0;
        slot_r    <= ~slot_r;
        q_valid_r <= 1'b1;
        q_func_r  <= in_func;
        q_len_r   <= len_nxt;
        q_ovf_r   <= ovf_nxt;
        q_slot_r  <= slot_r;
      end else begin
        len_r <= len_nxt;
        ovf_r <= ovf_nxt;
        if (stat.pop) begin
          q_valid_r <= 1'b0;
        end
      end
      cnt_r <= cnt_r + 2'(push) - 2'(stat.job_done);
    end
  end

  assign q_valid = q_valid_r;
  assign q_func  = q_func_r;
  assign q_len   = q_len_r;
  assign q_ovf   = q_ovf_r;
  assign q_slot  = q_slot_r;

endmodule

// File: hw/rtl/bfse_sha.sv
module bfse_sha (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         init,
  input  logic         start,
  input  logic [511:0] blk,
  output logic         done,
  output logic [31:0]  digest [8]
);

  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  rnd_r;
  logic        busy_r, fin_r;
  logic [31:0] t1, t2, s0, s1, wnew;

  always_comb begin
    t1 = v_r[7] + (bfse_pkg::rotr(v_r[4], 6) ^ bfse_pkg::rotr(v_r[4], 11)
         ^ bfse_pkg::rotr(v_r[4], 25)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + bfse_pkg::SHA_K[rnd_r] + w_r[0];
    t2 = (bfse_pkg::rotr(v_r[0], 2) ^ bfse_pkg::rotr(v_r[0], 13)
         ^ bfse_pkg::rotr(v_r[0], 22))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    s0 = bfse_pkg::rotr(w_r[1], 7) ^ bfse_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = bfse_pkg::rotr(w_r[14], 17) ^ bfse_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      fin_r <= busy_r && (rnd_r == 6'(bfse_pkg::SHA_ROUNDS - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (rnd_r == 6'(bfse_pkg::SHA_ROUNDS - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      for (int i = 0; i < 8; i++) h_r[i] <= bfse_pkg::SHA_IV[i];
    end else if (fin_r) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
    if (start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      for (int i = 0; i < 16; i++) w_r[i] <= blk[511-32*i -: 32];
      rnd_r <= '0;
    end else if (busy_r) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
      rnd_r   <= rnd_r + 6'd1;
    end
  end

  assign done = fin_r;
  always_comb begin
    for (int i = 0; i < 8; i++) digest[i] = h_r[i];
  end

endmodule

// File: hw/rtl/bfse_back.sv
module bfse_back #(
  parameter int unsigned MAP_BITS      = bfse_pkg::MAP_BITS_DEF,
  parameter int unsigned MAX_KEY_BYTES = bfse_pkg::MAX_KEY_BYTES_DEF,
  parameter int unsigned MAX_HASHES    = bfse_pkg::MAX_HASHES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  logic                                  q_func,
  input  logic [$clog2(MAX_KEY_BYTES+1)-1:0]    q_len,
  input  logic                                  q_ovf,
  input  logic                                  q_slot,
  input  logic                                  kwr_en,
  input  logic [$clog2(2*MAX_KEY_BYTES)-1:0]    kwr_addr,
  input  logic [7:0]                            kwr_data,
  input  logic [255:0]                          seed,
  input  logic [4:0]                            map_log2,
  input  logic [5:0]                            hash_count,
  output bfse_pkg::bk_stat_t                    stat,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_found,
  output logic                                  out_status
);

  localparam int unsigned AW     = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
  localparam int unsigned KDEPTH = 2 * MAX_KEY_BYTES;
  localparam int unsigned KAW    = $clog2(KDEPTH);
  localparam int unsigned LENW   = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned PW     = $clog2(MAX_KEY_BYTES + bfse_pkg::HDR_BYTES + 73);
  localparam int unsigned BW     = PW - 6;
  localparam logic [32:0] RECIP  = 33'((64'd1 << 32) / 64'(MAP_BITS));
  localparam logic [32:0] DIVC   = 33'(MAP_BITS);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HINIT, S_LOAD, S_START, S_RUN, S_DIG, S_RED, S_FIX, S_ACC, S_CHK,
    S_RES
  } state_t;

  state_t        state_r;
  logic          func_r, slot_r, status_r, all_r;
  logic [PW-1:0] l_r, tail_r;
  logic [BW-1:0] nblk_r, blk_idx_r;
  logic [5:0]    k_r, hidx_r, hn;
  logic [1:0]    ctr_r;
  logic [6:0]    j_r;
  logic          pend_v_r, pend_key_r;
  logic [7:0]    pend_byte_r, kq_r;
  logic [511:0]  blk_r;
  logic [31:0]   val_r, mask, masked;
  logic [AW-1:0] rem_r, clr_r;
  logic [31:0]   quo_r;
  logic [32:0]   diff_r, qd_lo;
  logic [63:0]   prod;
  logic          out_valid_r, out_found_r, out_status_r;
  logic          bm_q_r;

  logic          bmap [MAP_BITS];

  logic [PW-1:0]  p, koff, lsum;
  logic [KAW-1:0] kaddr;
  logic [7:0]     src_byte;
  logic           src_key;
  logic [63:0]    bl64;
  logic [2:0]     lb;
  logic [5:0]     ksat;
  logic           sha_init, sha_start, sha_done;
  logic [31:0]    digest [8];
  logic           bm_we, bm_wd;
  logic [AW-1:0]  bm_waddr;
  logic           out_free;

  logic [7:0] kmem_b [KDEPTH];

  bfse_sha u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .init   (sha_init),
    .start  (sha_start),
    .blk    (blk_r),
    .done   (sha_done),
    .digest (digest)
  );

  assign p     = {blk_idx_r, j_r[5:0]};
  assign koff  = p - PW'(bfse_pkg::HDR_BYTES);
  assign kaddr = slot_r ? KAW'(MAX_KEY_BYTES) + KAW'(koff) : KAW'(koff);
  assign bl64  = 64'(l_r) << 3;
  assign lb    = 3'(p - tail_r);
  assign lsum  = PW'(bfse_pkg::HDR_BYTES) + PW'(q_len);
  assign ksat  = (hash_count > 6'(MAX_HASHES)) ? 6'(MAX_HASHES) : hash_count;
  assign mask  = ~(32'hffff_ffff << map_log2);
  assign masked = digest[hidx_r[2:0]] & mask;
  assign prod  = {32'd0, masked} * {31'd0, RECIP};
  assign qd_lo = {1'b0, quo_r} * DIVC;
  assign hn    = hidx_r + 6'd1;
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    src_key  = 1'b0;
    src_byte = 8'h00;
    if (p < PW'(32)) begin
      src_byte = seed[{5'(5'd31 - p[4:0]), 3'b000} +: 8];
    end else if (p < PW'(bfse_pkg::HDR_BYTES)) begin
      src_byte = (p == PW'(bfse_pkg::HDR_BYTES - 1)) ? 8'(ctr_r) : 8'h00;
    end else if (p < l_r) begin
      src_key = 1'b1;
    end else if (p == l_r) begin
      src_byte = bfse_pkg::PAD_BYTE;
    end else if (p >= tail_r) begin
      src_byte = bl64[{3'(3'd7 - lb), 3'b000} +: 8];
    end
  end

  assign sha_init  = (state_r == S_HINIT);
  assign sha_start = (state_r == S_START);
  assign bm_we     = (state_r == S_CLR) | ((state_r == S_ACC) & (func_r == bfse_pkg::FUNC_ADD));
  assign bm_waddr  = (state_r == S_CLR) ? clr_r : rem_r;
  assign bm_wd     = (state_r == S_ACC);

  assign stat.clearing = (state_r == S_CLR);
  assign stat.pop      = (state_r == S_IDLE) & q_valid;
  assign stat.job_done = (state_r == S_RES) & out_free;

  always_ff @(posedge clk) begin
    if (kwr_en) kmem_b[kwr_addr] <= kwr_data;
    kq_r <= kmem_b[kaddr];
  end

  always_ff @(posedge clk) begin
    if (bm_we) bmap[bm_waddr] <= bm_wd;
    bm_q_r <= bmap[rem_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_RES) out_valid_r <= 1'b0;
      if (pend_v_r) blk_r <= {blk_r[503:0], pend_key_r ? kq_r : pend_byte_r};
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MAP_BITS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            func_r   <= q_func;
            slot_r   <= q_slot;
            status_r <= q_ovf;
            all_r    <= 1'b1;
            l_r      <= lsum;
            nblk_r   <= BW'((lsum + PW'(72)) >> 6);
            tail_r   <= {BW'((lsum + PW'(72)) >> 6), 6'b0} - PW'(bfse_pkg::LEN_BYTES);
            k_r      <= ksat;
            hidx_r   <= '0;
            ctr_r    <= '0;
            state_r  <= (q_ovf || ksat == 6'd0) ? S_RES : S_HINIT;
          end
        end
        S_HINIT: begin
          blk_idx_r <= '0;
          j_r       <= '0;
          state_r   <= S_LOAD;
        end
        S_LOAD: begin
          pend_v_r    <= ~j_r[6];
          pend_key_r  <= src_key;
          pend_byte_r <= src_byte;
          j_r         <= j_r + 7'd1;
          if (j_r[6]) state_r <= S_START;
        end
        S_START: state_r <= S_RUN;
        S_RUN: begin
          if (sha_done) begin
            if ({1'b0, blk_idx_r} + (BW+1)'(1) < {1'b0, nblk_r}) begin
              blk_idx_r <= blk_idx_r + BW'(1);
              j_r       <= '0;
              state_r   <= S_LOAD;
            end else begin
              state_r <= S_DIG;
            end
          end
        end
        S_DIG: begin
          if ({1'b0, masked} < 33'(MAP_BITS)) begin
            rem_r   <= AW'(masked);
            state_r <= S_ACC;
          end else begin
            val_r   <= masked;
            quo_r   <= prod[63:32];
            state_r <= S_RED;
          end
        end
        S_RED: begin
          diff_r  <= {1'b0, val_r} - qd_lo;
          state_r <= S_FIX;
        end
        S_FIX: begin
          rem_r   <= (diff_r >= DIVC) ? AW'(diff_r - DIVC) : AW'(diff_r);
          state_r <= S_ACC;
        end
        S_ACC, S_CHK: begin
          if (state_r == S_ACC && func_r == bfse_pkg::FUNC_TEST) begin
            state_r <= S_CHK;
          end else begin
            if (state_r == S_CHK && !bm_q_r) all_r <= 1'b0;
            hidx_r <= hn;
            if (hn == k_r) begin
              state_r <= S_RES;
            end else if (hn[2:0] == 3'd0) begin
              ctr_r   <= ctr_r + 2'd1;
              state_r <= S_HINIT;
            end else begin
              state_r <= S_DIG;
            end
          end
        end
        S_RES: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_found_r  <= (func_r == bfse_pkg::FUNC_TEST) & all_r & ~status_r;
            out_status_r <= status_r ? bfse_pkg::STATUS_TOO_LONG : bfse_pkg::STATUS_DONE;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    sha_done |-> state_r == S_RUN)
    else $error("hash finished outside its wait state");

  a_hidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIG |-> hidx_r < k_r)
    else $error("hash index beyond count");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    stat.job_done |=> out_valid_r)
    else $error("finished job did not reach the output register");

  a_blk_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> blk_idx_r < nblk_r)
    else $error("block index beyond message");

endmodule

// File: hw/rtl/bloom_filter_sha256_engine_unit.sv
// Bloom filter engine: adds keys to a bit map or tests them, hashing each key
// with SHA-256 over the seed, a 4-byte counter and the key bytes.
// Input channel: one key byte per transfer (in_byte_valid marks a real byte),
// in_last closes the key and in_func of that transfer selects add or test.
// Output channel: one transfer per key with out_found and out_status.
// Configuration channel: cfg_index selects seed words, map size or hash count;
// cfg_ready is always high. Write only while no key is in flight.
// Key bytes are taken one per cycle while in_stall is low, into one of two
// key slots, so a second key can stream in while the first is hashed.
// Per key, each group of eight indices costs one SHA-256 pass: each message
// block is assembled byte by byte from the key store and then run through the rounds
// (one block for keys up to 19 bytes, two for longer keys). Each index then
// writes its map bit for add, or reads and checks it for test, and is first
// reduced modulo the map size when the masked hash is not below it. The result
// is registered in the output register once the last index is done.
// After reset the map is cleared one bit per cycle, and in_stall stays high
// until that ends. A stalled result holds in the output register while the
// engine keeps working on the next key.
module bloom_filter_sha256_engine_unit #(
  parameter int unsigned MAP_BITS      = bfse_pkg::MAP_BITS_DEF,
  parameter int unsigned MAX_KEY_BYTES = bfse_pkg::MAX_KEY_BYTES_DEF,
  parameter int unsigned MAX_HASHES    = bfse_pkg::MAX_HASHES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_func,
  input  logic [7:0]                            in_key_byte,
  input  logic                                  in_byte_valid,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_found,
  output logic                                  out_status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bfse_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bfse_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int unsigned LENW = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned KAW  = $clog2(2 * MAX_KEY_BYTES);

  logic [255:0]       seed_r;
  logic [4:0]         map_log2_r;
  logic [5:0]         hash_count_r;
  bfse_pkg::bk_stat_t stat;
  logic               q_valid, q_func, q_ovf, q_slot;
  logic [LENW-1:0]    q_len;
  logic               kwr_en;
  logic [KAW-1:0]     kwr_addr;
  logic [7:0]         kwr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= '0;
      map_log2_r   <= 5'd16;
      hash_count_r <= 6'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bfse_pkg::REG_SEED0:      seed_r[255:192] <= cfg_data;
        bfse_pkg::REG_SEED1:      seed_r[191:128] <= cfg_data;
        bfse_pkg::REG_SEED2:      seed_r[127:64]  <= cfg_data;
        bfse_pkg::REG_SEED3:      seed_r[63:0]    <= cfg_data;
        bfse_pkg::REG_MAP_LOG2:   map_log2_r      <= cfg_data[4:0];
        bfse_pkg::REG_HASH_COUNT: hash_count_r    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  bfse_front #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_key_byte   (in_key_byte),
    .in_byte_valid (in_byte_valid),
    .in_last       (in_last),
    .stat          (stat),
    .q_valid       (q_valid),
    .q_func        (q_func),
    .q_len         (q_len),
    .q_ovf         (q_ovf),
    .q_slot        (q_slot),
    .kwr_en        (kwr_en),
    .kwr_addr      (kwr_addr),
    .kwr_data      (kwr_data)
  );

  bfse_back #(
    .MAP_BITS      (MAP_BITS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .MAX_HASHES    (MAX_HASHES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_func     (q_func),
    .q_len      (q_len),
    .q_ovf      (q_ovf),
    .q_slot     (q_slot),
    .kwr_en     (kwr_en),
    .kwr_addr   (kwr_addr),
    .kwr_data   (kwr_data),
    .seed       (seed_r),
    .map_log2   (map_log2_r),
    .hash_count (hash_count_r),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_found  (out_found),
    .out_status (out_status)
  );

endmodule

// File: verif/bfse_checker.sv
`timescale 1ns / 1ps
module bfse_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_func,
  input  logic [7:0]                      in_key_byte,
  input  logic                            in_byte_valid,
  input  logic                            in_last,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_found,
  input  logic                            out_status,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bfse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfse_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              pending_count
);

  localparam int unsigned MAP_SIZE = 65536;
  localparam int unsigned KEY_CAP  = 64;
  localparam int unsigned HASH_CAP = 32;

  typedef struct packed {
    logic found;
    logic status;
  } bloom_verdict_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic           map_bits [0:MAP_SIZE-1];
  logic [7:0]     key_bytes [0:KEY_CAP-1];
  int unsigned    key_len;
  logic           key_ovf;
  logic [63:0]    seed_words [0:3];
  logic [4:0]     map_log2_r;
  logic [5:0]     hash_count_r;
  logic [7:0]     msg_bytes [0:127];
  logic [31:0]    digest [0:7];
  bloom_verdict_t verdict_q [$];
  int             err_total;

  initial begin
    for (int i = 0; i < MAP_SIZE; i++) map_bits[i] = 1'b0;
    for (int i = 0; i < 4; i++) seed_words[i] = '0;
    key_len = 0;
    key_ovf = 1'b0;
    map_log2_r = 5'd16;
    hash_count_r = 6'd8;
    err_total = 0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [7:0] padded_byte(input int p, input int len, input int tail,
                                             input logic [63:0] bitlen);
    if (p < len) return msg_bytes[p];
    if (p == len) return 8'h80;
    if (p >= tail) return bitlen[8 * (7 - (p - tail)) +: 8];
    return 8'h00;
  endfunction

  function automatic void run_sha(input int len);
    logic [31:0] w [0:63];
    logic [31:0] v [0:7];
    logic [31:0] t1, t2, s0, s1;
    logic [63:0] bitlen;
    int nblk, tail, base;
    bitlen = 64'(len) * 64'd8;
    nblk = (len + 72) / 64;
    tail = nblk * 64 - 8;
    for (int h = 0; h < 8; h++) digest[h] = HASH_INIT[h];
    for (int b = 0; b < nblk; b++) begin
      base = b * 64;
      for (int i = 0; i < 16; i++) begin
        w[i] = {padded_byte(base + 4 * i, len, tail, bitlen),
                padded_byte(base + 4 * i + 1, len, tail, bitlen),
                padded_byte(base + 4 * i + 2, len, tail, bitlen),
                padded_byte(base + 4 * i + 3, len, tail, bitlen)};
      end
      for (int i = 16; i < 64; i++) begin
        s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int h = 0; h < 8; h++) v[h] = digest[h];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int h = 0; h < 8; h++) digest[h] = digest[h] + v[h];
    end
  endfunction

  function automatic bloom_verdict_t close_key(input logic func);
    bloom_verdict_t res;
    logic [63:0] mask;
    logic [31:0] masked;
    int unsigned hashes;
    logic all_set;
    res = '0;
    if (key_ovf) begin
      res.status = bfse_pkg::STATUS_TOO_LONG;
      return res;
    end
    for (int s = 0; s < 4; s++)
      for (int i = 0; i < 8; i++) msg_bytes[8 * s + i] = seed_words[s][56 - 8 * i +: 8];
    for (int i = 0; i < key_len; i++) msg_bytes[36 + i] = key_bytes[i];
    hashes = (hash_count_r > HASH_CAP) ? HASH_CAP : hash_count_r;
    mask = (64'd1 << map_log2_r) - 64'd1;
    all_set = 1'b1;
    for (int i = 0; i < hashes; i++) begin
      if (i % 8 == 0) begin
        {msg_bytes[32], msg_bytes[33], msg_bytes[34], msg_bytes[35]} = 32'(i / 8);
        run_sha(36 + key_len);
      end
      masked = digest[i % 8] & mask[31:0];
      if (func == bfse_pkg::FUNC_ADD) map_bits[masked[15:0]] = 1'b1;
      else if (!map_bits[masked[15:0]]) all_set = 1'b0;
    end
    res.found = (func == bfse_pkg::FUNC_TEST) && all_set;
    res.status = bfse_pkg::STATUS_DONE;
    return res;
  endfunction

  always @(posedge clk) begin
    bloom_verdict_t exp_v;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          err_total++;
          if (err_total <= 10)
            $display("%0t: result transfer with none expected: found=%b status=%b",
                     $realtime, out_found, out_status);
        end else begin
          exp_v = verdict_q.pop_front();
          if (exp_v.found !== out_found || exp_v.status !== out_status) begin
            err_total++;
            if (err_total <= 10)
              $display("%0t: mismatch: expected found=%b status=%b, got found=%b status=%b",
                       $realtime, exp_v.found, exp_v.status, out_found, out_status);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bfse_pkg::REG_SEED0:      seed_words[0] = cfg_data;
          bfse_pkg::REG_SEED1:      seed_words[1] = cfg_data;
          bfse_pkg::REG_SEED2:      seed_words[2] = cfg_data;
          bfse_pkg::REG_SEED3:      seed_words[3] = cfg_data;
          bfse_pkg::REG_MAP_LOG2:   map_log2_r = cfg_data[4:0];
          bfse_pkg::REG_HASH_COUNT: hash_count_r = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_byte_valid) begin
          if (key_len < KEY_CAP) begin
            key_bytes[key_len] = in_key_byte;
            key_len++;
          end else begin
            key_ovf = 1'b1;
          end
        end
        if (in_last) begin
          verdict_q.push_back(close_key(in_func));
          key_len = 0;
          key_ovf = 1'b0;
        end
      end
    end
    mismatch_count <= err_total;
    pending_count <= verdict_q.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 55;
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned LONG_HOLD   = 400;
  localparam logic [bfse_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_func;
  logic [7:0]                      in_key_byte;
  logic                            in_byte_valid;
  logic                            in_last;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_found;
  logic                            out_status;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bfse_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bfse_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              mismatch_count;
  int                              pending_count;

  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned rx_wait;
  logic        no_idle;
  logic        long_hold;

  bloom_filter_sha256_engine_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_key_byte   (in_key_byte),
    .in_byte_valid (in_byte_valid),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_status    (out_status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bfse_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_key_byte    (in_key_byte),
    .in_byte_valid  (in_byte_valid),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The long hold lets the input side fill both key slots and back up.
  initial begin
    out_stall <= 1'b0;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (rx_wait > 0) begin
        rx_wait--;
        if (rx_wait == 0) out_stall <= 1'b0;
      end else if (long_hold) begin
        long_hold = 1'b0;
        rx_wait = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        rx_wait = draw_gap();
        if (rx_wait > 0) out_stall <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic func, input logic [7:0] kbyte, input logic bvalid,
                           input logic last);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_key_byte <= kbyte;
    in_byte_valid <= bvalid;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    if (bvalid || last) items_sent++;
  endtask

  task automatic send_key(input logic func, input int unsigned len, input logic narrow,
                          input logic noisy, input logic empty_close);
    logic [7:0] b;
    if (len == 0) begin
      send_item(func, 8'($urandom), 1'b0, 1'b1);
      return;
    end
    for (int j = 0; j < len; j++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_item(1'($urandom), 8'($urandom), 1'b0, 1'b0);
      b = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
      if (j == len - 1 && !empty_close) send_item(func, b, 1'b1, 1'b1);
      else send_item(1'($urandom), b, 1'b1, 1'b0);
    end
    if (empty_close) send_item(func, 8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_random_key();
    int unsigned r, len;
    r = $urandom_range(0, 99);
    if (r < 5) len = $urandom_range(50, 70);
    else if (r < 10) len = 0;
    else len = $urandom_range(1, 10);
    send_key(1'($urandom), len, 1'($urandom), $urandom_range(0, 3) == 0,
             len > 0 && $urandom_range(0, 6) == 0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bfse_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin
    logic [4:0] map_sizes [PHASES];
    logic [5:0] hash_counts [PHASES];
    logic [63:0] seed;
    int unsigned start;
    logic burst_done;
    logic paused;
    map_sizes = '{5'd16, 5'd0, 5'd5, 5'd20, 5'd31, 5'd12, 5'd16, 5'd1};
    hash_counts = '{6'd8, 6'd0, 6'd1, 6'd32, 6'd63, 6'd9, 6'd24, 6'd8};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = bfse_pkg::FUNC_ADD;
    in_key_byte = 8'h00;
    in_byte_valid = 1'b0;
    in_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = bfse_pkg::REG_SEED0;
    cfg_data = '0;
    items_sent = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    long_hold = 1'b0;
    burst_done = 1'b0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(bfse_pkg::FUNC_ADD, 8'h00, 1'b0, 1'b1);
    send_item(bfse_pkg::FUNC_TEST, 8'hff, 1'b0, 1'b1);
    send_item(bfse_pkg::FUNC_TEST, 8'h00, 1'b1, 1'b0);
    send_item(bfse_pkg::FUNC_TEST, 8'h5a, 1'b0, 1'b0);
    send_item(bfse_pkg::FUNC_ADD, 8'hff, 1'b1, 1'b1);
    send_item(bfse_pkg::FUNC_ADD, 8'h00, 1'b1, 1'b0);
    send_item(bfse_pkg::FUNC_TEST, 8'hff, 1'b1, 1'b1);
    send_item(bfse_pkg::FUNC_TEST, 8'hff, 1'b1, 1'b0);
    send_item(bfse_pkg::FUNC_TEST, 8'h00, 1'b1, 1'b1);
    send_item(bfse_pkg::FUNC_ADD, 8'haa, 1'b1, 1'b0);
    send_item(bfse_pkg::FUNC_ADD, 8'h55, 1'b0, 1'b1);
    send_item(bfse_pkg::FUNC_TEST, 8'haa, 1'b1, 1'b1);
    send_item(bfse_pkg::FUNC_TEST, 8'h55, 1'b1, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      for (int s = 0; s < 4; s++) begin
        if (ph == 0) seed = '1;
        else if (ph == 1) seed = '0;
        else seed = {$urandom, $urandom};
        write_reg(bfse_pkg::CFG_IDX_W'(bfse_pkg::REG_SEED0) + bfse_pkg::CFG_IDX_W'(s), seed);
      end
      write_reg(bfse_pkg::REG_MAP_LOG2, 64'(map_sizes[ph]));
      write_reg(bfse_pkg::REG_HASH_COUNT, 64'(hash_counts[ph]));
      if (ph == 1) write_reg(REG_SPARE, {$urandom, $urandom});
      cfg_valid <= 1'b0;
      @(posedge clk);
      no_idle = (ph == 3 || ph == 6);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if (ph == 2 && !burst_done && items_sent - start > 10) begin
          burst_done = 1'b1;
          long_hold = 1'b1;
          no_idle = 1'b1;
          repeat (6) send_key(1'($urandom), $urandom_range(1, 4), 1'b1, 1'b0, 1'b0);
          no_idle = 1'b0;
        end
        if (ph == 1 && !paused && items_sent - start > 20) begin
          paused = 1'b1;
          drain_results();
        end
        send_random_key();
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
